>>> rtl/core/dpsp_pkg.sv
// Package for the dual pedal sensor plausibility unit.
// Shared widths, register indexes and the structs passed between lanes, merge and top.
// No dependencies.
package dpsp_pkg;

	localparam int ADC_BITS   = 10;
	localparam int FULL_SCALE = 1000;
	localparam int TRAVEL_W   = 10;
	localparam int MARGIN_W   = 8;
	localparam int WINDOW_W   = 16;
	localparam int TIME_W     = 32;
	localparam int FS_W       = $clog2(FULL_SCALE + 1);
	localparam int PROD_W     = ADC_BITS + FS_W;
	localparam int DIV_CNT_W  = $clog2(TRAVEL_W);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam int IN_FIELDS_W  = 2 * ADC_BITS + TIME_W;
	localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = 3 * TRAVEL_W + 5;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam logic [TRAVEL_W-1:0] FULL_TRAVEL = TRAVEL_W'(FULL_SCALE);

	localparam logic [CFG_IDX_W-1:0] REG_A_MIN   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_A_MAX   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_B_MIN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_B_MAX   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MARGIN  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = 3'd6;

	typedef struct packed {
		logic start;
		logic ack;
	} lane_ctl_t;

	typedef struct packed {
		logic [TRAVEL_W-1:0] travel;
		logic                range_fault;
	} lane_res_t;

	typedef struct packed {
		logic                motor_cut;
		logic                fault_pending;
		logic                fault_now;
		logic                range_fault_b;
		logic                range_fault_a;
		logic [TRAVEL_W-1:0] travel_gap;
		logic [TRAVEL_W-1:0] travel_b;
		logic [TRAVEL_W-1:0] travel_a;
	} result_t;

endpackage

>>> rtl/core/dpsp_lane.sv
// One sensor lane: widened span check and travel mapping.
// Travel uses a one-bit-per-cycle restoring divider. Depends on dpsp_pkg.
module dpsp_lane (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dpsp_pkg::lane_ctl_t       ctl,
	input  logic [dpsp_pkg::ADC_BITS-1:0] raw,
	input  logic [dpsp_pkg::ADC_BITS-1:0] span_min,
	input  logic [dpsp_pkg::ADC_BITS-1:0] span_max,
	input  logic [dpsp_pkg::MARGIN_W-1:0] margin,
	output dpsp_pkg::lane_res_t       res,
	output logic                      done
);
	import dpsp_pkg::*;

	typedef enum logic [1:0] {LN_IDLE, LN_PREP, LN_DIV, LN_DONE} lane_state_t;

	lane_state_t          state_q;
	logic [DIV_CNT_W-1:0] cnt_q;

	logic [ADC_BITS-1:0]  raw_q;
	logic [ADC_BITS-1:0]  rem_q;
	logic [ADC_BITS-1:0]  div_q;
	logic [TRAVEL_W-1:0]  quo_q;
	logic                 zero_q;
	logic                 sat_q;
	logic                 rf_q;

	logic signed [ADC_BITS:0] diff;
	logic signed [ADC_BITS:0] span;
	logic [ADC_BITS-1:0]      abs_d;
	logic [ADC_BITS-1:0]      abs_s;
	logic [PROD_W-1:0]        prod;
	logic [ADC_BITS:0]        trial;
	logic                     take;
	logic                     rf;

	always_comb begin
		diff  = $signed({1'b0, raw_q}) - $signed({1'b0, span_min});
		span  = $signed({1'b0, span_max}) - $signed({1'b0, span_min});
		abs_d = diff[ADC_BITS] ? ADC_BITS'(-diff) : diff[ADC_BITS-1:0];
		abs_s = span[ADC_BITS] ? ADC_BITS'(-span) : span[ADC_BITS-1:0];
		prod  = PROD_W'(abs_d) * PROD_W'(FULL_SCALE);
		rf    = (({1'b0, raw_q} + (ADC_BITS+1)'(margin)) < {1'b0, span_min})
		     || ({1'b0, raw_q} > ({1'b0, span_max} + (ADC_BITS+1)'(margin)));
		trial = {rem_q, quo_q[TRAVEL_W-1]};
		take  = trial >= {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LN_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				LN_IDLE: if (ctl.start) state_q <= LN_PREP;
				LN_PREP: begin
					state_q <= LN_DIV;
					cnt_q   <= DIV_CNT_W'(TRAVEL_W - 1);
				end
				LN_DIV: begin
					if (cnt_q == '0) state_q <= LN_DONE;
					else cnt_q <= cnt_q - 1'b1;
				end
				LN_DONE: if (ctl.ack) state_q <= LN_IDLE;
				default: state_q <= LN_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == LN_IDLE && ctl.start) raw_q <= raw;
		if (state_q == LN_PREP) begin
			// quotient fits TRAVEL_W bits once the saturating case is set aside
			zero_q <= (span == '0) || (diff == '0) || (diff[ADC_BITS] != span[ADC_BITS]);
			sat_q  <= abs_d >= abs_s;
			rf_q   <= rf;
			div_q  <= abs_s;
			rem_q  <= prod[PROD_W-1:TRAVEL_W];
			quo_q  <= prod[TRAVEL_W-1:0];
		end else if (state_q == LN_DIV) begin
			rem_q <= take ? ADC_BITS'(trial - {1'b0, div_q}) : trial[ADC_BITS-1:0];
			quo_q <= {quo_q[TRAVEL_W-2:0], take};
		end
	end

	assign done            = (state_q == LN_DONE);
	assign res.range_fault = rf_q;
	assign res.travel      = zero_q ? '0 : (sat_q ? FULL_TRAVEL : quo_q);

endmodule

>>> rtl/core/dpsp_merge.sv
// Merge stage: travel gap, fault decision, persistence timer and latched cut.
// Combines both lane results. Depends on dpsp_pkg.
module dpsp_merge (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dpsp_pkg::lane_res_t           lane_a,
	input  dpsp_pkg::lane_res_t           lane_b,
	input  logic [dpsp_pkg::TIME_W-1:0]   now_ms,
	input  logic [dpsp_pkg::TRAVEL_W-1:0] disagree_limit,
	input  logic [dpsp_pkg::WINDOW_W-1:0] fault_window_ms,
	input  logic                          commit,
	output dpsp_pkg::result_t             res,
	output logic                          cut
);
	import dpsp_pkg::*;

	logic              pending_q;
	logic              cut_q;
	logic [TIME_W-1:0] start_q;

	logic [TRAVEL_W-1:0] gap;
	logic [TIME_W-1:0]   elapsed;
	logic                fault;
	logic                cut_nx;

	always_comb begin
		gap     = (lane_a.travel >= lane_b.travel) ? lane_a.travel - lane_b.travel
		                                           : lane_b.travel - lane_a.travel;
		fault   = (gap > disagree_limit) || lane_a.range_fault || lane_b.range_fault;
		elapsed = now_ms - start_q;
		cut_nx  = fault && pending_q && (elapsed > TIME_W'(fault_window_ms));
		if (cut_q) begin
			res           = '0;
			res.motor_cut = 1'b1;
		end else begin
			res.travel_a      = lane_a.travel;
			res.travel_b      = lane_b.travel;
			res.travel_gap    = gap;
			res.range_fault_a = lane_a.range_fault;
			res.range_fault_b = lane_b.range_fault;
			res.fault_now     = fault;
			res.fault_pending = fault;
			res.motor_cut     = cut_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
			cut_q     <= 1'b0;
			start_q   <= '0;
		end else if (commit && !cut_q) begin
			pending_q <= fault;
			if (fault && !pending_q) start_q <= now_ms;
			if (cut_nx) cut_q <= 1'b1;
		end
	end

	assign cut = cut_q;

endmodule

>>> rtl/core/dual_pedal_sensor_plausibility_unit.sv
// Top level of the dual pedal sensor plausibility unit.
// Holds the config registers, the request sequencer and the result register.
// Depends on dpsp_pkg, dpsp_lane and dpsp_merge.
//
// Each request carries one pair of raw pedal samples and a millisecond
// timestamp and yields exactly one result. Both sensors are handled in two
// lanes side by side, each with its own span check and a restoring divider
// that produces one quotient bit per cycle; the merge stage then forms the
// travel gap, the fault flag and the persistence timer. After acceptance a
// request passes one setup step, the divider steps and a hand-over into
// the result register; the next request is taken the cycle after, so
// requests are handled one at a time, and the hand-over waits while the
// output side holds a result; the result register lets the next request
// start while a result waits. Once motor cut has latched, each request
// returns only the cut flag until reset. Config writes belong to idle
// periods.
module dual_pedal_sensor_plausibility_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// sensor_a_raw, sensor_b_raw, now_ms, zero pad
	input  logic [dpsp_pkg::IN_TDATA_W-1:0]   s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// travel_a, travel_b, travel_gap, range_fault_a, range_fault_b,
	// fault_now, fault_pending, motor_cut, zero pad
	output logic [dpsp_pkg::OUT_TDATA_W-1:0]  m_tdata,
	input  logic                              cfg_we,
	input  logic [dpsp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dpsp_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import dpsp_pkg::*;

	typedef enum logic {ST_IDLE, ST_RUN} top_state_t;

	top_state_t state_q;

	logic [ADC_BITS-1:0] a_min_q, a_max_q, b_min_q, b_max_q;
	logic [MARGIN_W-1:0] margin_q;
	logic [TRAVEL_W-1:0] limit_q;
	logic [WINDOW_W-1:0] window_q;

	logic [TIME_W-1:0] now_q;
	result_t           out_q;
	result_t           merged;
	lane_ctl_t         lane_ctl;
	lane_res_t         res_a, res_b;
	logic              done_a, done_b;
	logic              cut;
	logic              accept;
	logic              commit;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign commit   = (state_q == ST_RUN) && done_a && (!m_tvalid || m_tready);

	assign lane_ctl.start = accept;
	assign lane_ctl.ack   = commit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_min_q  <= ADC_BITS'(64);
			a_max_q  <= ADC_BITS'(642);
			b_min_q  <= ADC_BITS'(93);
			b_max_q  <= ADC_BITS'(516);
			margin_q <= MARGIN_W'(15);
			limit_q  <= TRAVEL_W'(100);
			window_q <= WINDOW_W'(100);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_A_MIN:  a_min_q  <= cfg_data[ADC_BITS-1:0];
				REG_A_MAX:  a_max_q  <= cfg_data[ADC_BITS-1:0];
				REG_B_MIN:  b_min_q  <= cfg_data[ADC_BITS-1:0];
				REG_B_MAX:  b_max_q  <= cfg_data[ADC_BITS-1:0];
				REG_MARGIN: margin_q <= cfg_data[MARGIN_W-1:0];
				REG_LIMIT:  limit_q  <= cfg_data[TRAVEL_W-1:0];
				REG_WINDOW: window_q <= cfg_data[WINDOW_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			m_tvalid <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (accept) state_q <= ST_RUN;
				ST_RUN:  if (commit) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			if (commit) m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) now_q <= s_tdata[2*ADC_BITS +: TIME_W];
		if (commit) out_q <= merged;
	end

	dpsp_lane u_lane_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (lane_ctl),
		.raw      (s_tdata[0 +: ADC_BITS]),
		.span_min (a_min_q),
		.span_max (a_max_q),
		.margin   (margin_q),
		.res      (res_a),
		.done     (done_a)
	);

	dpsp_lane u_lane_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (lane_ctl),
		.raw      (s_tdata[ADC_BITS +: ADC_BITS]),
		.span_min (b_min_q),
		.span_max (b_max_q),
		.margin   (margin_q),
		.res      (res_b),
		.done     (done_b)
	);

	dpsp_merge u_merge (
		.clk             (clk),
		.arst_n          (arst_n),
		.lane_a          (res_a),
		.lane_b          (res_b),
		.now_ms          (now_q),
		.disagree_limit  (limit_q),
		.fault_window_ms (window_q),
		.commit          (commit),
		.res             (merged),
		.cut             (cut)
	);

	assign m_tdata = {(OUT_TDATA_W - OUT_FIELDS_W)'(0), out_q};

	a_lanes_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		done_a == done_b)
		else $error("lanes out of step");

	a_cut_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		cut |=> cut)
		else $error("motor cut released");

	a_pending_needs_fault: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_q.fault_pending |-> out_q.fault_now)
		else $error("pending without fault");

	a_cut_result_blank: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_q.motor_cut && !out_q.fault_pending |->
		out_q.travel_a == '0 && out_q.travel_b == '0 && out_q.travel_gap == '0
		&& !out_q.fault_now)
		else $error("cut result carries evaluation");

endmodule
